FILE: hw/rtl/rde_pkg.sv
package rde_pkg;

  localparam int DEF_VALUE_BITS = 64;
  localparam int STEP_BITS      = 8;

  localparam logic [4:0] RADIX_MIN   = 5'd2;
  localparam logic [4:0] RADIX_MAX   = 5'd16;
  localparam logic [6:0] CHAR_ZERO   = 7'd48;
  localparam logic [6:0] CHAR_ALPHA  = 7'd55;
  localparam logic [6:0] CASE_OFFSET = 7'd32;

  typedef struct packed {
    logic [63:0] value;
    logic [4:0]  radix;
    logic        lowercase;
  } in_item_t;

  typedef struct packed {
    logic [6:0] digit_char;
    logic       last;
  } out_item_t;

  // head of the front queue as seen by the back end
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } q_head_t;

  function automatic logic [6:0] digit_glyph(input logic [3:0] d, input logic lower);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {3'd0, d};
    end else begin
      c = CHAR_ALPHA + {3'd0, d};
      if (lower) begin
        c = c + CASE_OFFSET;
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/rde_ram.sv
module rde_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/rde_front.sv
module rde_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  rde_pkg::in_item_t in_item,
  output rde_pkg::q_head_t  q_head,
  input  logic              q_pop
);
  import rde_pkg::*;

  in_item_t   q_mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] occ_r, occ_nxt;
  logic       accept;
  logic       radix_ok;
  logic       q_push;

  assign in_full = (occ_r == 2'd2);
  assign accept  = in_push && !in_full;

  always_comb begin
    radix_ok = in_item.radix inside {[RADIX_MIN:RADIX_MAX]};
  end

  // drop transactions with a base outside the supported range
  assign q_push = accept && radix_ok;

  always_comb begin
    wptr_nxt = wptr_r ^ q_push;
    rptr_nxt = rptr_r ^ q_pop;
    occ_nxt  = occ_r + {1'b0, q_push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      occ_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      occ_r  <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem_r[wptr_r] <= in_item;
    end
  end

  assign q_head.valid = (occ_r != 2'd0);
  assign q_head.item  = q_mem_r[rptr_r];

endmodule

FILE: hw/rtl/rde_back.sv
module rde_back #(
  parameter int VALUE_BITS = rde_pkg::DEF_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rde_pkg::q_head_t   q_head,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output rde_pkg::out_item_t out_item
);
  import rde_pkg::*;

  localparam int CHUNKS   = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_BITS = CHUNKS * STEP_BITS;
  localparam int CW       = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int AW       = $clog2(VALUE_BITS);
  localparam int CNTW     = $clog2(VALUE_BITS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [PAD_BITS-1:0] val_r, val_nxt;
  logic [4:0]          radix_r, radix_nxt;
  logic                lower_r, lower_nxt;
  logic [3:0]          rem_r, rem_nxt;
  logic [CW-1:0]       chunk_r, chunk_nxt;
  logic [CNTW-1:0]     ndig_r, ndig_nxt;
  logic [CNTW-1:0]     rd_cnt_r, rd_cnt_nxt;

  logic [CW-1:0]       top_chunk;
  logic [STEP_BITS-1:0] quo_byte;
  logic [3:0]          rem_step;

  logic                ram_we;
  logic                ram_re;
  logic [CNTW-1:0]     rd_addr_full;
  logic [AW-1:0]       rd_addr;
  logic [3:0]          ram_rdata;

  logic                infl_r;
  logic                infl_last_r;
  logic                infl_lower_r;

  out_item_t           buf_r [2];
  logic                buf_wptr_r, buf_rptr_r;
  logic [1:0]          occ_r, occ_nxt;
  logic                pop_acc;
  logic [2:0]          credit_used;

  // highest chunk of the current value that holds a set bit
  always_comb begin
    top_chunk = '0;
    for (int i = 0; i < CHUNKS; i++) begin
      if (|val_r[i*STEP_BITS +: STEP_BITS]) begin
        top_chunk = CW'(i);
      end
    end
  end

  // restoring long division of one chunk by the radix, one bit per step
  always_comb begin
    logic [3:0]           r;
    logic [4:0]           t;
    logic [STEP_BITS-1:0] dbyte;
    r     = rem_r;
    dbyte = val_r[chunk_r*STEP_BITS +: STEP_BITS];
    for (int b = STEP_BITS - 1; b >= 0; b--) begin
      t = {r, dbyte[b]};
      if (t >= radix_r) begin
        quo_byte[b] = 1'b1;
        t = t - radix_r;
      end else begin
        quo_byte[b] = 1'b0;
      end
      r = t[3:0];
    end
    rem_step = r;
  end

  assign pop_acc     = out_pop && !out_empty;
  assign credit_used = {1'b0, occ_r} + {2'b0, infl_r} - {2'b0, pop_acc};

  assign rd_addr_full = rd_cnt_r - CNTW'(1);
  assign rd_addr      = rd_addr_full[AW-1:0];

  always_comb begin
    state_nxt  = state_r;
    val_nxt    = val_r;
    radix_nxt  = radix_r;
    lower_nxt  = lower_r;
    rem_nxt    = rem_r;
    chunk_nxt  = chunk_r;
    ndig_nxt   = ndig_r;
    rd_cnt_nxt = rd_cnt_r;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_head.valid) begin
          q_pop     = 1'b1;
          val_nxt   = PAD_BITS'(q_head.item.value[VALUE_BITS-1:0]);
          radix_nxt = q_head.item.radix;
          lower_nxt = q_head.item.lowercase;
          ndig_nxt  = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // a zero value still runs one pass so that it yields a single zero digit
        if ((val_r == '0) && (ndig_r != '0)) begin
          rd_cnt_nxt = ndig_r;
          state_nxt  = ST_EMIT;
        end else begin
          chunk_nxt = top_chunk;
          rem_nxt   = 4'd0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        val_nxt[chunk_r*STEP_BITS +: STEP_BITS] = quo_byte;
        rem_nxt = rem_step;
        if (chunk_r == '0) begin
          ram_we    = 1'b1;
          ndig_nxt  = ndig_r + CNTW'(1);
          state_nxt = ST_SCAN;
        end else begin
          chunk_nxt = chunk_r - CW'(1);
        end
      end
      ST_EMIT: begin
        if (rd_cnt_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (credit_used < 3'd2) begin
          ram_re     = 1'b1;
          rd_cnt_nxt = rd_cnt_r - CNTW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      infl_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      infl_r  <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    val_r        <= val_nxt;
    radix_r      <= radix_nxt;
    lower_r      <= lower_nxt;
    rem_r        <= rem_nxt;
    chunk_r      <= chunk_nxt;
    ndig_r       <= ndig_nxt;
    rd_cnt_r     <= rd_cnt_nxt;
    infl_last_r  <= (rd_cnt_r == CNTW'(1));
    infl_lower_r <= lower_r;
  end

  // digits land least significant first and are read back in reverse
  rde_ram #(
    .WIDTH (4),
    .DEPTH (VALUE_BITS)
  ) u_digit_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ndig_r[AW-1:0]),
    .wdata (rem_step),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // two-entry output buffer, filled only against free credit
  always_comb begin
    occ_nxt = occ_r + {1'b0, infl_r} - {1'b0, pop_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r      <= 2'd0;
      buf_wptr_r <= 1'b0;
      buf_rptr_r <= 1'b0;
    end else begin
      occ_r      <= occ_nxt;
      buf_wptr_r <= buf_wptr_r ^ infl_r;
      buf_rptr_r <= buf_rptr_r ^ pop_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (infl_r) begin
      buf_r[buf_wptr_r].digit_char <= digit_glyph(ram_rdata, infl_lower_r);
      buf_r[buf_wptr_r].last       <= infl_last_r;
    end
  end

  assign out_empty = (occ_r == 2'd0);
  assign out_item  = buf_r[buf_rptr_r];

  a_buf_credit: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, occ_r} + {2'b0, infl_r}) <= 3'd2)
    else $error("output buffer credit exceeded");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < radix_r))
    else $error("partial remainder not below radix");

  a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (ndig_r < CNTW'(VALUE_BITS)))
    else $error("digit count beyond value width");

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && rd_cnt_r == '0) |=> (state_r == ST_IDLE))
    else $error("emit phase did not finish");

endmodule

FILE: hw/rtl/radix_digit_emitter_core.sv
// Radix digit emitter: converts an unsigned value into ASCII digits in base 2..16.
//
// Input channel: queue style, in_push / in_full. One transaction carries value,
// radix and lowercase. A transaction with a radix outside 2..16 is taken and
// dropped without any result.
// Result channel: queue style, out_empty / out_pop. One transaction per digit,
// most significant first; last is set on the final digit. Zero yields one '0'.
// Timing: a two-entry input queue decouples intake from conversion. Each digit
// takes a scan step and then a division step for each 8-bit chunk, from the
// highest set chunk of the current quotient down. Digits are then read back from
// the digit RAM at one per cycle while the output buffer has free credit, once the
// sequencer has passed from the last division pass through the scan state.
// The division unit (8 bits per cycle) sets the rate unless the output stalls.
// Reset: synchronous rst_n clears the queues and the sequencer; no memory sweep.
// Stall: when out_pop stays low the two-entry output buffer fills and digit
// readout holds; the input queue keeps accepting until it is full.
module radix_digit_emitter_core #(
  parameter int VALUE_BITS = rde_pkg::DEF_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  rde_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output rde_pkg::out_item_t out_item
);
  import rde_pkg::*;

  q_head_t q_head;
  logic    q_pop;

  rde_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  rde_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rde_pkg::*;

  localparam int          DRAIN_CYCLES = 800;
  localparam int          MAX_SHOWN    = 10;
  localparam logic [7:0]  GLYPH_DIGIT  = "0";
  localparam logic [7:0]  GLYPH_UPPER  = "A";
  localparam logic [7:0]  GLYPH_LOWER  = "a";

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_item = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_item;

  out_item_t   expected_digits[$];
  int unsigned digit_errors = 0;
  int unsigned pop_hold = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;

  radix_digit_emitter_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #40ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic bit radix_ok(input logic [4:0] radix);
    return radix >= RADIX_MIN && radix <= RADIX_MAX;
  endfunction

  // Queue the characters that one conversion must produce, most significant first.
  function automatic void predict_digits(input in_item_t it);
    logic [63:0] quot;
    logic [63:0] base;
    logic [3:0]  digs[$];
    logic [7:0]  ch;
    out_item_t   want;
    if (!radix_ok(it.radix)) return;
    quot = it.value;
    base = {59'd0, it.radix};
    if (quot == 64'd0) begin
      digs.push_front(4'd0);
    end
    while (quot != 64'd0) begin
      digs.push_front(4'(quot % base));
      quot = quot / base;
    end
    for (int k = 0; k < digs.size(); k++) begin
      if (digs[k] < 4'd10) begin
        ch = GLYPH_DIGIT + {4'd0, digs[k]};
      end else begin
        ch = (it.lowercase ? GLYPH_LOWER : GLYPH_UPPER) + {4'd0, digs[k]} - 8'd10;
      end
      want.digit_char = ch[6:0];
      want.last = (k == digs.size() - 1);
      expected_digits.push_back(want);
    end
  endfunction

  task automatic check_digit(input out_item_t got);
    out_item_t want;
    if (expected_digits.size() == 0) begin
      digit_errors++;
      if (digit_errors <= MAX_SHOWN) begin
        $display("unexpected digit: char=%0d last=%0b", got.digit_char, got.last);
      end
    end else begin
      want = expected_digits.pop_front();
      if (got.digit_char !== want.digit_char || got.last !== want.last) begin
        digit_errors++;
        if (digit_errors <= MAX_SHOWN) begin
          $display("digit mismatch: expected char=%0d last=%0b, got char=%0d last=%0b",
                   want.digit_char, want.last, got.digit_char, got.last);
        end
      end
    end
  endtask

  // Result side: check each accepted transaction, then may stall for a random count.
  always @(posedge clk) begin : digit_sink
    int unsigned hold;
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_hold <= 0;
    end else if (out_pop && !out_empty) begin
      check_digit(out_item);
      hold = rx_idle_on ? $urandom_range(0, 14) : 0;
      if (hold != 0) begin
        out_pop <= 1'b0;
        pop_hold <= hold - 1;
      end
    end else if (!out_pop) begin
      if (pop_hold == 0) begin
        out_pop <= 1'b1;
      end else begin
        pop_hold <= pop_hold - 1;
      end
    end
  end

  task automatic send_item(input logic [63:0] value, input logic [4:0] radix,
                           input logic lowercase);
    in_item_t    it;
    int unsigned gap;
    it.value = value;
    it.radix = radix;
    it.lowercase = lowercase;
    gap = tx_idle_on ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full);
    predict_digits(it);
  endtask

  function automatic logic [63:0] rand_value();
    logic [63:0]  v;
    int unsigned  nbits;
    v = {$urandom, $urandom};
    nbits = $urandom_range(0, 64);
    if (nbits < 64) begin
      v = v & ((64'd1 << nbits) - 64'd1);
    end
    return v;
  endfunction

  function automatic logic [4:0] rand_bad_radix();
    int unsigned r;
    r = $urandom_range(0, 16);
    return (r < 2) ? 5'(r) : 5'(r + 15);
  endfunction

  task automatic test_zero();
    send_item(64'd0, 5'd10, 1'b0);
    send_item(64'd0, RADIX_MIN, 1'b1);
    send_item(64'd0, RADIX_MAX, 1'b0);
  endtask

  task automatic test_extremes();
    send_item('1, RADIX_MIN, 1'b0);
    send_item('1, RADIX_MAX, 1'b0);
    send_item('1, RADIX_MAX, 1'b1);
    send_item('1, 5'd3, 1'b1);
    send_item('1, 5'd10, 1'b0);
    send_item(64'd1, RADIX_MAX, 1'b0);
    send_item(64'd1, RADIX_MIN, 1'b1);
    send_item(64'd15, RADIX_MAX, 1'b1);
    send_item(64'd10, 5'd11, 1'b0);
    send_item(64'h8000_0000_0000_0000, RADIX_MIN, 1'b0);
  endtask

  task automatic test_all_glyphs();
    send_item(64'hfedc_ba98_7654_3210, RADIX_MAX, 1'b0);
    send_item(64'hfedc_ba98_7654_3210, RADIX_MAX, 1'b1);
    send_item(64'h0123_4567_89ab_cdef, RADIX_MAX, 1'b1);
  endtask

  // Out-of-range bases are taken and dropped; a valid item follows to prove it.
  task automatic test_bad_radix();
    send_item(64'd123, 5'd0, 1'b0);
    send_item(64'd123, 5'd1, 1'b1);
    send_item('1, 5'd17, 1'b0);
    send_item('1, 5'd31, 1'b1);
    send_item(64'd123, 5'd10, 1'b0);
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned done;
    int unsigned in_stretch;
    logic [4:0]  radix;
    done = 0;
    in_stretch = 0;
    while (done < n_items) begin
      // switch idling on and off in stretches of items
      if (in_stretch == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
        in_stretch = $urandom_range(20, 60);
      end
      in_stretch--;
      radix = ($urandom_range(0, 19) == 0) ? rand_bad_radix() : 5'($urandom_range(2, 16));
      send_item(rand_value(), radix, 1'($urandom));
      if (radix_ok(radix)) done++;
    end
  endtask

  task automatic test_back_to_back(input int unsigned n_items);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (n_items) begin
      send_item(rand_value(), 5'($urandom_range(2, 16)), 1'($urandom));
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero();
    test_extremes();
    test_all_glyphs();
    test_bad_radix();
    test_random_traffic(330);
    test_back_to_back(60);
    drain();
    if (digit_errors == 0 && expected_digits.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
